// File: sv/delta_word_frame_pack_core_defines.svh
// Assertion shorthands shared by the delta frame packer modules.
`ifndef DELTA_WORD_FRAME_PACK_CORE_DEFINES_SVH
`define DELTA_WORD_FRAME_PACK_CORE_DEFINES_SVH

// cond must hold at every clock edge outside reset
`define DWFP_ASSERT_ALWAYS(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("dwfp invariant violated");

// when ante holds, cons must hold in the following cycle
`define DWFP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dwfp sequence violated");

`endif

// File: sv/dwfp_pkg.sv
`timescale 1ns / 1ps

package dwfp_pkg;

	localparam int SLOTS        = 16;
	localparam int HEADER_BYTES = 4;

	localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int POS_W      = $clog2(SLOTS + 1);
	localparam int BYTE_SUM_W = POS_W + 8;
	localparam int BYTE_COUNT_MAX = 127;

	localparam int OUT_DEPTH = 4;
	localparam int PTR_W     = $clog2(OUT_DEPTH);
	localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [15:0] word;
		logic        present;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [3:0]  packed_position;
		logic [15:0] packed_word;
		logic [15:0] change_mask;
		logic [6:0]  byte_count;
		logic        frame_end;
	} out_item_t;

	// results produced by one item: n of them, first in a, second in b
	typedef struct packed {
		logic [1:0] n;
		out_item_t  a;
		out_item_t  b;
	} push_t;

endpackage

// File: sv/delta_word_frame_pack_core.sv
`timescale 1ns / 1ps
// Delta frame packer: takes one beat per slot of a 16-slot frame (slot 0
// first), each beat a 16-bit word and its present bit from the frame mask.
// A present word that differs from the word last stored for its slot is
// stored and emitted as a data result at the next packed position; words of
// absent slots and unchanged words produce nothing. After slot 15 a summary
// result follows carrying the mask of changed slots and the packed frame
// size in bytes (header bytes + 2 + 2 per changed word, saturated at 127).
// Stored words start at zero after reset and survive from frame to frame.
// Rate: one item per cycle while the result queue has room; an item passes
// through an input register and then a four-entry result queue, and its
// first result is offered on the output once it is written to the queue.
// Throughput is bounded by the output side at one result per cycle, so a
// frame with every slot changed yields 17 results for its 16 items.
// The input stalls only when the result queue cannot take two more results.

module delta_word_frame_pack_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  dwfp_pkg::in_item_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output dwfp_pkg::out_item_t result
);
	import dwfp_pkg::*;

	push_t push;
	logic  room;

	// compare, store update and frame counters
	dwfp_encode u_encode (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.room       (room),
		.push       (push)
	);

	// hold results until the consumer takes each beat
	dwfp_out_fifo u_out_fifo (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// File: sv/dwfp_encode.sv
`timescale 1ns / 1ps
`include "delta_word_frame_pack_core_defines.svh"

module dwfp_encode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  dwfp_pkg::in_item_t item,
	input  logic              room,
	output dwfp_pkg::push_t   push
);
	import dwfp_pkg::*;

	logic               valid_s1;
	in_item_t           item_s1;
	logic [15:0]        prev_q [SLOTS];
	logic [SLOT_W-1:0]  slot_q;
	logic [POS_W-1:0]   pos_q;
	logic [15:0]        changed_q;

	logic                  adv;
	logic                  changed;
	logic                  last;
	logic [POS_W-1:0]      pos_next;
	logic [15:0]           mask_next;
	logic [BYTE_SUM_W-1:0] byte_sum;
	logic [6:0]            byte_count;
	out_item_t             data_res;
	out_item_t             sum_res;

	assign adv        = valid_s1 && room;
	assign item_ready = !valid_s1 || adv;

	assign changed   = item_s1.present && (prev_q[slot_q] != item_s1.word);
	assign last      = (slot_q == SLOT_W'(SLOTS - 1));
	assign pos_next  = pos_q + POS_W'(changed);
	// slot_q is at most 15, so every slot has its own mask bit
	assign mask_next = changed ? (changed_q | (16'(1) << slot_q)) : changed_q;
	assign byte_sum  = BYTE_SUM_W'(HEADER_BYTES + 2) + BYTE_SUM_W'({pos_next, 1'b0});
	assign byte_count = (byte_sum > BYTE_SUM_W'(BYTE_COUNT_MAX)) ?
		7'(BYTE_COUNT_MAX) : byte_sum[6:0];

	always_comb begin
		data_res                 = '0;
		data_res.kind            = KIND_DATA;
		data_res.packed_position = 4'(pos_q);
		data_res.packed_word     = item_s1.word;
		sum_res                  = '0;
		sum_res.kind             = KIND_SUMMARY;
		sum_res.change_mask      = mask_next;
		sum_res.byte_count       = byte_count;
		sum_res.frame_end        = 1'b1;

		push.a = changed ? data_res : sum_res;
		push.b = sum_res;
		push.n = adv ? (2'(changed) + 2'(last)) : 2'd0;
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// frame state and stored words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q    <= '0;
			pos_q     <= '0;
			changed_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				prev_q[i] <= '0;
			end
		end else if (adv) begin
			if (changed) begin
				prev_q[slot_q] <= item_s1.word;
			end
			if (last) begin
				slot_q    <= '0;
				pos_q     <= '0;
				changed_q <= '0;
			end else begin
				slot_q    <= slot_q + SLOT_W'(1);
				pos_q     <= pos_next;
				changed_q <= mask_next;
			end
		end
	end

	`DWFP_ASSERT_NEXT(a_frame_restart, clk, arst_n, adv && last,
		slot_q == '0 && pos_q == '0 && changed_q == '0)
	`DWFP_ASSERT_ALWAYS(a_pos_bounded, clk, arst_n,
		POS_W'(slot_q) >= pos_q)

endmodule

// File: sv/dwfp_out_fifo.sv
`timescale 1ns / 1ps
`include "delta_word_frame_pack_core_defines.svh"

module dwfp_out_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  dwfp_pkg::push_t     push,
	output logic                room,
	output logic                result_valid,
	input  logic                result_ready,
	output dwfp_pkg::out_item_t result
);
	import dwfp_pkg::*;

	out_item_t        store_q [OUT_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign pop          = result_valid && result_ready;
	assign result_valid = (count_q != '0);
	assign result       = store_q[rd_q];
	// room for the worst case of two results from one item
	assign room         = (count_q <= CNT_W'(OUT_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			store_q[wr_q] <= push.a;
		end
		if (push.n == 2'd2) begin
			store_q[wr_q + PTR_W'(1)] <= push.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + PTR_W'(push.n);
			rd_q    <= rd_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push.n) - CNT_W'(pop);
		end
	end

	`DWFP_ASSERT_ALWAYS(a_count_bounded, clk, arst_n,
		count_q <= CNT_W'(OUT_DEPTH))
	`DWFP_ASSERT_ALWAYS(a_push_fits, clk, arst_n,
		CNT_W'(push.n) + count_q <= CNT_W'(OUT_DEPTH))

endmodule
